### rtl/kmpe_pkg.sv
package kmpe_pkg;

  // Matrix geometry.
  localparam int unsigned COLUMNS = 6;
  localparam int unsigned ROWS    = 10;

  // Field widths of the channels.
  localparam int unsigned ROW_W   = 4;
  localparam int unsigned LEVEL_W = 6;
  localparam int unsigned CODE_W  = 8;
  localparam int unsigned COL_W   = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

  // Row whose codes past column 0 get the coupler nibble, not the table value.
  localparam logic [ROW_W-1:0] COUPLER_ROW  = ROW_W'(4);
  localparam logic [3:0]       COUPLER_CODE = 4'hA;

  // Press job queue between the front and back parts.
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // One row with at least one new press, as handed to the back part.
  typedef struct packed {
    logic [ROW_W-1:0]   row;
    logic [COLUMNS-1:0] press;
  } kmpe_job_t;

  // Queue occupancy status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } kmpe_q_stat_t;

  // Low nibble code of each drive line.
  function automatic logic [3:0] row_code(input logic [ROW_W-1:0] row);
    logic [3:0] code;
    case (row)
      ROW_W'(0): code = 4'h3;
      ROW_W'(1): code = 4'h2;
      ROW_W'(2): code = 4'h4;
      ROW_W'(3): code = 4'h5;
      ROW_W'(4): code = 4'hF;
      ROW_W'(5): code = 4'h7;
      ROW_W'(6): code = 4'h6;
      ROW_W'(7): code = 4'h9;
      ROW_W'(8): code = 4'h8;
      ROW_W'(9): code = 4'h1;
      default:   code = 4'h0;
    endcase
    return code;
  endfunction

  // Knob code of one switch. Column 0 takes the row code in its upper nibble.
  function automatic logic [CODE_W-1:0] knob_code(input logic [COL_W-1:0] col,
                                                  input logic [ROW_W-1:0] row);
    logic [CODE_W-1:0] code;
    logic [3:0]        low;
    logic [CODE_W-1:0] upper;
    low   = (row == COUPLER_ROW) ? COUPLER_CODE : row_code(row);
    upper = CODE_W'({col, 4'h0});
    if (col == '0) begin
      code = {row_code(row), 4'h0};
    end else begin
      code = upper + CODE_W'(low);
    end
    return code;
  endfunction

endpackage

### rtl/kmpe_if.sv
interface kmpe_in_if import kmpe_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ROW_W-1:0]   row_index;
  logic [LEVEL_W-1:0] column_levels;

  modport source (output valid, output row_index, output column_levels, input ready);
  modport sink   (input valid, input row_index, input column_levels, output ready);
endinterface

interface kmpe_out_if import kmpe_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] knob_code;
  logic              last_code;

  modport source (output valid, output knob_code, output last_code, input ready);
  modport sink   (input valid, input knob_code, input last_code, output ready);
endinterface

### rtl/kmpe_front.sv
module kmpe_front import kmpe_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  kmpe_in_if.sink      in_i,
  input  kmpe_q_stat_t stat_i,
  output logic         push_o,
  output kmpe_job_t    push_data_o
);

  logic [COLUMNS-1:0] flags_q [ROWS];
  logic [COLUMNS-1:0] levels;
  logic [COLUMNS-1:0] cur_flags;
  logic [COLUMNS-1:0] press;
  logic               row_ok;
  logic               accept;

  // Columns beyond the sense lines read as closed.
  for (genvar i = 0; i < COLUMNS; i++) begin : g_lev
    if (i < LEVEL_W) begin : g_real
      assign levels[i] = in_i.column_levels[i];
    end else begin : g_pad
      assign levels[i] = 1'b0;
    end
  end

  assign row_ok    = (in_i.row_index < ROW_W'(ROWS));
  assign cur_flags = row_ok ? flags_q[in_i.row_index] : '1;
  assign press     = ~levels & cur_flags;

  assign in_i.ready = !stat_i.full;
  assign accept     = in_i.valid && in_i.ready;

  assign push_o            = accept && row_ok && (press != '0);
  assign push_data_o.row   = in_i.row_index;
  assign push_data_o.press = press;

  // After a scan every open column is released and every closed one pressed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < ROWS; r++) begin
        flags_q[r] <= '1;
      end
    end else if (accept && row_ok) begin
      flags_q[in_i.row_index] <= levels;
    end
  end

endmodule

### rtl/kmpe_queue.sv
module kmpe_queue import kmpe_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  kmpe_job_t    push_data_i,
  input  logic         pop_i,
  output kmpe_job_t    pop_data_o,
  output kmpe_q_stat_t stat_o
);

  kmpe_job_t         mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign stat_o.full  = (cnt_q == QCNT_W'(QDEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |-> !stat_o.full)
    else $error("job pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !stat_o.empty)
    else $error("job popped from an empty queue");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QDEPTH))
    else $error("queue count beyond its depth");

endmodule

### rtl/kmpe_back.sv
module kmpe_back import kmpe_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  kmpe_q_stat_t stat_i,
  input  kmpe_job_t    pop_data_i,
  output logic         pop_o,
  kmpe_out_if.source   out_o
);

  logic               busy_q, busy_d;
  logic [ROW_W-1:0]   row_q, row_d;
  logic [COLUMNS-1:0] mask_q, mask_d;
  logic               out_valid_q, out_valid_d;
  logic [CODE_W-1:0]  code_q, code_d;
  logic               last_q, last_d;
  logic [COL_W-1:0]   col;
  logic [COLUMNS-1:0] rest;
  logic               emit;

  // Lowest pending column.
  always_comb begin
    col = '0;
    for (int i = COLUMNS - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        col = COL_W'(i);
      end
    end
  end

  assign rest  = mask_q & (mask_q - 1'b1);
  assign emit  = busy_q && (!out_valid_q || out_o.ready);
  assign pop_o = !busy_q && !stat_i.empty;

  always_comb begin
    busy_d      = busy_q;
    row_d       = row_q;
    mask_d      = mask_q;
    out_valid_d = out_valid_q;
    code_d      = code_q;
    last_d      = last_q;
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
      code_d      = knob_code(col, row_q);
      last_d      = (rest == '0);
      mask_d      = rest;
      busy_d      = (rest != '0);
    end else if (pop_o) begin
      busy_d = 1'b1;
      row_d  = pop_data_i.row;
      mask_d = pop_data_i.press;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q  <= row_d;
    mask_q <= mask_d;
    code_q <= code_d;
    last_q <= last_d;
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.knob_code = code_q;
  assign out_o.last_code = last_q;

  a_busy_has_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> mask_q != '0)
    else $error("serializer busy with no pending column");

  a_last_ends_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && rest == '0 |=> !busy_q && out_o.last_code)
    else $error("final code of a row not flagged as last");

endmodule

### rtl/key_matrix_press_encoder_unit.sv
// Key matrix press encoder.
// The in_i channel takes one scanned row per transfer: row_index and the
// column_levels of that row, where a low level means a closed switch. The
// out_o channel gives one transfer per newly pressed switch: its knob_code
// and last_code, which is set on the final code that a row produced.
// Codes of one row leave in column order, lowest column first.
// The front part keeps one released bit per switch and compares the row
// against it in the cycle of the transfer; a row with new presses becomes a
// job in a four-entry queue. The back part takes one job at a time and
// emits one code per cycle, unless out_o stalls, into an output register.
// A row's first code passes the queue, the back part's job registers and
// the output register. The back part takes no new job until it has
// emitted the last code of the current one. A row with no new press or an
// out-of-range row number is accepted by the front and adds no job.
// The front accepts a row in every cycle in which the queue has room.
// Reset marks every switch released and empties the queue and output.
// When the receiver stalls, the output register holds its code, the back
// part waits, the queue fills, and only then does in_i drop ready.
module key_matrix_press_encoder_unit import kmpe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  kmpe_in_if.sink    in_i,
  kmpe_out_if.source out_o
);

  kmpe_q_stat_t stat;
  logic         push;
  logic         pop;
  kmpe_job_t    push_data;
  kmpe_job_t    pop_data;

  // Classify each scanned row and track switch state.
  kmpe_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .stat_i      (stat),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // Decouple row scanning from code output.
  kmpe_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .stat_o      (stat)
  );

  // Serialize the pressed columns of a job into knob codes.
  kmpe_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .stat_i     (stat),
    .pop_data_i (pop_data),
    .pop_o      (pop),
    .out_o      (out_o)
  );

endmodule
